>>> sv/crdp_pkg.sv
// Shared types, field layout and defaults for the CSR row dot product block.
`default_nettype none

package crdp_pkg;

    // Default store sizes
    localparam int MAX_NONZEROS_DEF = 1024;
    localparam int MAX_ROWS_DEF     = 256;

    // Field widths of one input item and one result item
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 11;
    localparam int COL_W   = 8;
    localparam int DATUM_W = 32;
    localparam int ROW_W   = 8;
    localparam int MODE_W  = 2;
    localparam int SUM_W   = 32;
    localparam int ACC_W   = 64;
    localparam int FRAC_W  = 16;

    // Packing of the input tdata, lowest field first
    localparam int SLOT_LSB  = 0;
    localparam int COL_LSB   = SLOT_LSB + SLOT_W;
    localparam int DATUM_LSB = COL_LSB + COL_W;
    localparam int ROW_LSB   = DATUM_LSB + DATUM_W;
    localparam int MODE_LSB  = ROW_LSB + ROW_W;
    localparam int S_FIELDS_W = MODE_LSB + MODE_W;
    localparam int S_TDATA_W = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = SUM_W;
    localparam int M_TUSER_W = 1;

    // Item commands
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_ENTRY = 2'd0,
        CMD_LOAD_PTR   = 2'd1,
        CMD_LOAD_VEC   = 2'd2,
        CMD_ROW        = 2'd3
    } cmd_t;

    // Row walk modes; any other code walks the full row
    localparam logic [MODE_W-1:0] MODE_LOWER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UPPER = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PTR,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic start_walk;
        logic issue;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_row;
        logic more;
        logic pipe_empty;
        logic out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

>>> sv/crdp_ctrl.sv
// Controller state machine that sequences loads and row walks.
`default_nettype none

module crdp_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire crdp_pkg::ctrl_status_t status,
    output crdp_pkg::ctrl_cmd_t        cmd
);

    crdp_pkg::state_t state_reg;
    crdp_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= crdp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            crdp_pkg::ST_IDLE: begin
                // No item is taken while reset is held.
                s_tready   = aresetn;
                cmd.accept = s_tvalid && aresetn;
                if (cmd.accept && status.is_row) begin
                    state_next = crdp_pkg::ST_PTR;
                end
            end
            crdp_pkg::ST_PTR: begin
                cmd.start_walk = 1'b1;
                state_next     = crdp_pkg::ST_WALK;
            end
            crdp_pkg::ST_WALK: begin
                if (status.more) begin
                    cmd.issue = 1'b1;
                end else begin
                    state_next = crdp_pkg::ST_DRAIN;
                end
            end
            crdp_pkg::ST_DRAIN: begin
                if (status.pipe_empty) begin
                    state_next = crdp_pkg::ST_DONE;
                end
            end
            crdp_pkg::ST_DONE: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = crdp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = crdp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/crdp_dp.sv
// Datapath: matrix, pointer and vector stores, walk pipeline, accumulator
// and output register.
`default_nettype none

module crdp_dp #(
    parameter int MAX_NONZEROS = crdp_pkg::MAX_NONZEROS_DEF,
    parameter int MAX_ROWS     = crdp_pkg::MAX_ROWS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [crdp_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic [crdp_pkg::S_TUSER_W-1:0]  s_tuser,
    input  wire crdp_pkg::ctrl_cmd_t             cmd,
    output crdp_pkg::ctrl_status_t               status,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [crdp_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [crdp_pkg::M_TUSER_W-1:0]       m_tuser
);

    // Only slots that the slot field can reach are stored
    localparam int SLOT_SPAN = 1 << crdp_pkg::SLOT_W;
    localparam int ROW_SPAN  = 1 << crdp_pkg::ROW_W;
    localparam int ENT_DEPTH = (MAX_NONZEROS < SLOT_SPAN) ? MAX_NONZEROS : SLOT_SPAN;
    localparam int ENT_AW    = $clog2(ENT_DEPTH);
    localparam int PTR_W     = $clog2(MAX_NONZEROS + 1);
    localparam int VEC_DEPTH = (MAX_ROWS < ROW_SPAN) ? MAX_ROWS : ROW_SPAN;
    localparam int VEC_AW    = $clog2(VEC_DEPTH);
    localparam int RS_DEPTH  = VEC_DEPTH + 1;
    localparam int RS_AW     = $clog2(RS_DEPTH);
    localparam int Q_W       = crdp_pkg::ACC_W - crdp_pkg::FRAC_W;

    // Item fields
    logic [crdp_pkg::SLOT_W-1:0]         in_slot;
    logic [crdp_pkg::COL_W-1:0]          in_col;
    logic signed [crdp_pkg::DATUM_W-1:0] in_datum;
    logic [crdp_pkg::ROW_W-1:0]          in_row;
    logic [crdp_pkg::MODE_W-1:0]         in_mode;
    crdp_pkg::cmd_t                      in_cmd;

    assign in_slot  = s_tdata[crdp_pkg::SLOT_LSB +: crdp_pkg::SLOT_W];
    assign in_col   = s_tdata[crdp_pkg::COL_LSB +: crdp_pkg::COL_W];
    assign in_datum = $signed(s_tdata[crdp_pkg::DATUM_LSB +: crdp_pkg::DATUM_W]);
    assign in_row   = s_tdata[crdp_pkg::ROW_LSB +: crdp_pkg::ROW_W];
    assign in_mode  = s_tdata[crdp_pkg::MODE_LSB +: crdp_pkg::MODE_W];
    assign in_cmd   = crdp_pkg::cmd_t'(s_tuser);

    // Stores
    logic signed [crdp_pkg::DATUM_W-1:0] ent_val_mem [ENT_DEPTH];
    logic [crdp_pkg::COL_W-1:0]          ent_col_mem [ENT_DEPTH];
    logic [PTR_W-1:0]                    rs_mem      [RS_DEPTH];
    logic signed [crdp_pkg::DATUM_W-1:0] vec_mem     [VEC_DEPTH];

    // Row pointer value clamped to the number of nonzeros
    logic [PTR_W-1:0] ptr_val;
    assign ptr_val = ($unsigned(in_datum) > 32'(MAX_NONZEROS)) ?
                     PTR_W'(MAX_NONZEROS) : in_datum[PTR_W-1:0];

    // Row pointer read addresses for a row item
    logic             in_row_ok;
    logic [RS_AW-1:0] rs_addr_lo;
    logic [RS_AW-1:0] rs_addr_hi;
    assign in_row_ok  = 32'(in_row) < VEC_DEPTH;
    assign rs_addr_lo = in_row_ok ? RS_AW'(in_row) : '0;
    assign rs_addr_hi = rs_addr_lo + RS_AW'(1);

    // Row item registers
    logic [crdp_pkg::ROW_W-1:0]  row_reg;
    logic [crdp_pkg::MODE_W-1:0] mode_reg;
    logic                        row_ok_reg;
    logic [PTR_W-1:0]            rs_lo_reg;
    logic [PTR_W-1:0]            rs_hi_reg;

    // Loads write the stores; a row item reads its two row pointers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            unique case (in_cmd)
                crdp_pkg::CMD_LOAD_ENTRY: begin
                    if (32'(in_slot) < ENT_DEPTH) begin
                        ent_val_mem[in_slot[ENT_AW-1:0]] <= in_datum;
                        ent_col_mem[in_slot[ENT_AW-1:0]] <= in_col;
                    end
                end
                crdp_pkg::CMD_LOAD_PTR: begin
                    if (32'(in_slot) < RS_DEPTH) begin
                        rs_mem[in_slot[RS_AW-1:0]] <= ptr_val;
                    end
                end
                crdp_pkg::CMD_LOAD_VEC: begin
                    if (32'(in_slot) < VEC_DEPTH) begin
                        vec_mem[in_slot[VEC_AW-1:0]] <= in_datum;
                    end
                end
                crdp_pkg::CMD_ROW: begin
                    rs_lo_reg  <= rs_mem[rs_addr_lo];
                    rs_hi_reg  <= rs_mem[rs_addr_hi];
                    row_reg    <= in_row;
                    mode_reg   <= in_mode;
                    row_ok_reg <= in_row_ok;
                end
                default: begin
                end
            endcase
        end
    end

    // Walk index
    logic [PTR_W-1:0] j_reg;
    always_ff @(posedge aclk) begin
        if (cmd.start_walk) begin
            j_reg <= rs_lo_reg;
        end else if (cmd.issue) begin
            j_reg <= j_reg + PTR_W'(1);
        end
    end

    // Stage one: entry read
    logic                                v1_reg;
    logic signed [crdp_pkg::DATUM_W-1:0] val1_reg;
    logic [crdp_pkg::COL_W-1:0]          col1_reg;
    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            val1_reg <= ent_val_mem[j_reg[ENT_AW-1:0]];
            col1_reg <= ent_col_mem[j_reg[ENT_AW-1:0]];
        end
    end

    // Mode filter; a strictly lower walk stops at its first entry on or above the diagonal
    logic is_lower;
    logic is_upper;
    logic hit_stop;
    logic keep1;
    logic col_ok1;
    logic stop_reg;
    assign is_lower = mode_reg == crdp_pkg::MODE_LOWER;
    assign is_upper = mode_reg == crdp_pkg::MODE_UPPER;
    assign hit_stop = is_lower && (col1_reg >= row_reg);
    assign col_ok1  = 32'(col1_reg) < VEC_DEPTH;
    assign keep1    = !stop_reg && !hit_stop && !(is_upper && (col1_reg <= row_reg))
                      && col_ok1;

    always_ff @(posedge aclk) begin
        if (cmd.start_walk) begin
            stop_reg <= 1'b0;
        end else if (v1_reg && hit_stop) begin
            stop_reg <= 1'b1;
        end
    end

    // Stage two: vector element read
    logic                                v2_reg;
    logic                                keep2_reg;
    logic signed [crdp_pkg::DATUM_W-1:0] val2_reg;
    logic signed [crdp_pkg::DATUM_W-1:0] vec2_reg;
    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            keep2_reg <= keep1;
            val2_reg  <= val1_reg;
            vec2_reg  <= vec_mem[col1_reg[VEC_AW-1:0]];
        end
    end

    // Stage three: product
    logic                              v3_reg;
    logic signed [crdp_pkg::ACC_W-1:0] prod3_reg;
    always_ff @(posedge aclk) begin
        if (v2_reg) begin
            prod3_reg <= val2_reg * vec2_reg;
        end
    end

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && keep2_reg;
        end
    end

    // Stage four: saturating Q32.32 accumulate
    logic signed [crdp_pkg::ACC_W-1:0] acc_reg;
    logic signed [crdp_pkg::ACC_W-1:0] acc_next;
    logic signed [crdp_pkg::ACC_W-1:0] acc_raw;
    logic                              acc_ovf;
    assign acc_raw = acc_reg + prod3_reg;
    assign acc_ovf = (acc_reg[crdp_pkg::ACC_W-1] == prod3_reg[crdp_pkg::ACC_W-1]) &&
                     (acc_raw[crdp_pkg::ACC_W-1] != acc_reg[crdp_pkg::ACC_W-1]);

    always_comb begin
        if (acc_ovf) begin
            acc_next = prod3_reg[crdp_pkg::ACC_W-1] ?
                       {1'b1, {(crdp_pkg::ACC_W-1){1'b0}}} :
                       {1'b0, {(crdp_pkg::ACC_W-1){1'b1}}};
        end else begin
            acc_next = acc_raw;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_walk) begin
            acc_reg <= '0;
        end else if (v3_reg) begin
            acc_reg <= acc_next;
        end
    end

    // Floor to Q16.16 and clip to the 32-bit range
    logic signed [Q_W-1:0]             q_val;
    logic                              q_clip;
    logic signed [crdp_pkg::SUM_W-1:0] q_sum;
    assign q_val  = acc_reg[crdp_pkg::ACC_W-1:crdp_pkg::FRAC_W];
    assign q_clip = !((&q_val[Q_W-1:crdp_pkg::SUM_W-1]) ||
                      !(|q_val[Q_W-1:crdp_pkg::SUM_W-1]));
    always_comb begin
        if (q_clip) begin
            q_sum = q_val[Q_W-1] ? {1'b1, {(crdp_pkg::SUM_W-1){1'b0}}} :
                                   {1'b0, {(crdp_pkg::SUM_W-1){1'b1}}};
        end else begin
            q_sum = q_val[crdp_pkg::SUM_W-1:0];
        end
    end

    // Output register
    logic                              out_valid_reg;
    logic signed [crdp_pkg::SUM_W-1:0] sum_reg;
    logic                              sat_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            sum_reg <= q_sum;
            sat_reg <= q_clip;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sum_reg;
    assign m_tuser  = sat_reg;

    // Status to the controller
    assign status.is_row     = in_cmd == crdp_pkg::CMD_ROW;
    assign status.more       = row_ok_reg && (j_reg < rs_hi_reg);
    assign status.pipe_empty = !v1_reg && !v2_reg && !v3_reg;
    assign status.out_free   = !out_valid_reg || m_tready;

endmodule

`default_nettype wire

>>> sv/csr_row_dot_product_top.sv
// Top level of the CSR sparse row times dense vector dot product block.
//
//   channel  direction  tdata                         tuser
//   s_       in         slot, column, datum,          command
//                       target_row, mode
//   m_       out        sum                           saturated
//
// A load item is taken while idle; a row product takes no further item until it is done:
// pointer read, one entry per cycle on the single entry read port, then the vector read,
// multiply and accumulate stages drain before the result is loaded.
// Reset is synchronous and active low; the stores are not cleared.
// A waiting result blocks only a later row product, which holds at its end, taking no items, until the result is taken.
`default_nettype none

module csr_row_dot_product_top #(
    parameter int MAX_NONZEROS = crdp_pkg::MAX_NONZEROS_DEF,
    parameter int MAX_ROWS     = crdp_pkg::MAX_ROWS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // slot[10:0], column[18:11], datum[50:19], target_row[58:51],
    // mode[60:59], zero[63:61]
    input  wire logic [crdp_pkg::S_TDATA_W-1:0]  s_tdata,
    // command[1:0]
    input  wire logic [crdp_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // sum[31:0]
    output logic [crdp_pkg::M_TDATA_W-1:0]       m_tdata,
    // saturated[0]
    output logic [crdp_pkg::M_TUSER_W-1:0]       m_tuser
);

    crdp_pkg::ctrl_cmd_t    cmd;
    crdp_pkg::ctrl_status_t status;

    // Sequencer
    crdp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Stores and arithmetic
    crdp_dp #(
        .MAX_NONZEROS (MAX_NONZEROS),
        .MAX_ROWS     (MAX_ROWS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

>>> sv/crdp_chk.sv
// Port level checker for the CSR row dot product block, with its bind.
`default_nettype none

module crdp_chk (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [crdp_pkg::S_TUSER_W-1:0]  s_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [crdp_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic [crdp_pkg::M_TUSER_W-1:0]  m_tuser
);

    // A stalled result stays valid.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A saturated result sits at one end of the Q16.16 range.
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
        (m_tdata == 32'h7fff_ffff || m_tdata == 32'h8000_0000))
        else $error("saturation flag with an unclipped sum");

    // A row product item starts a walk, so no item is taken in the next cycle.
    a_row_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == crdp_pkg::CMD_ROW) |=> !s_tready)
        else $error("item accepted during a row walk");

endmodule

bind csr_row_dot_product_top crdp_chk u_crdp_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> tb/crdp_tb_pkg.sv
// Stimulus item type and the scoreboard that predicts row dot products.
`timescale 1ns / 100ps

package crdp_tb_pkg;
    import crdp_pkg::*;

    localparam int NZ_DEPTH     = MAX_NONZEROS_DEF;
    localparam int ROW_DEPTH    = MAX_ROWS_DEF;
    localparam int REPORT_LIMIT = 10;

    // Mode codes that walk the whole row
    localparam logic [MODE_W-1:0] MODE_FULL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;
    localparam longint Q_MAX   = 64'sd2147483647;
    localparam longint Q_MIN   = -64'sd2147483648;

    // One input item, as the testbench sees it
    typedef struct packed {
        cmd_t               cmd;
        logic [SLOT_W-1:0]  slot;
        logic [COL_W-1:0]   column;
        logic [DATUM_W-1:0] datum;
        logic [ROW_W-1:0]   target_row;
        logic [MODE_W-1:0]  mode;
    } crdp_item_t;

    // One result item
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             saturated;
    } row_result_t;

    class row_product_scoreboard;
        int               entry_value  [NZ_DEPTH];
        logic [COL_W-1:0] entry_column [NZ_DEPTH];
        bit               entry_set    [NZ_DEPTH];
        int unsigned      row_start    [ROW_DEPTH + 1];
        bit               start_set    [ROW_DEPTH + 1];
        int               vector_elem  [ROW_DEPTH];
        bit               vector_set   [ROW_DEPTH];
        row_result_t      expected_sums [$];
        int               mismatches;

        // Apply one accepted item to the stores; returns 0 when the block ignores it.
        function bit note_item(crdp_item_t it);
            int unsigned ptr;
            case (it.cmd)
                CMD_LOAD_ENTRY: begin
                    if (it.slot >= NZ_DEPTH) return 0;
                    entry_value[it.slot]  = it.datum;
                    entry_column[it.slot] = it.column;
                    entry_set[it.slot]    = 1'b1;
                end
                CMD_LOAD_PTR: begin
                    if (it.slot > ROW_DEPTH) return 0;
                    // The pointer is unsigned and clamps at the store size.
                    ptr = it.datum;
                    if (ptr > NZ_DEPTH) ptr = NZ_DEPTH;
                    row_start[it.slot] = ptr;
                    start_set[it.slot] = 1'b1;
                end
                CMD_LOAD_VEC: begin
                    if (it.slot >= ROW_DEPTH) return 0;
                    vector_elem[it.slot] = it.datum;
                    vector_set[it.slot]  = 1'b1;
                end
                CMD_ROW: begin
                    expected_sums.insert(expected_sums.size(),
                                         predict_row_sum(it.target_row, it.mode));
                end
            endcase
            return 1;
        endfunction

        // Walk one row in Q32.32 with a saturating accumulator, then floor to Q16.16.
        function row_result_t predict_row_sum(logic [ROW_W-1:0] row, logic [MODE_W-1:0] mode);
            longint      acc;
            longint      prod;
            longint      q;
            logic [64:0] wide;
            int unsigned j;
            int unsigned c;
            row_result_t res;
            acc = 0;
            for (j = row_start[row]; j < row_start[row + 1] && j < NZ_DEPTH; j++) begin
                c = entry_column[j];
                if (mode == MODE_LOWER && c >= row) break;
                if (mode == MODE_UPPER && c <= row) continue;
                prod = longint'(entry_value[j]) * longint'(vector_elem[c]);
                wide = {acc[63], acc} + {prod[63], prod};
                if (wide[64] != wide[63]) begin
                    acc = wide[64] ? ACC_MIN : ACC_MAX;
                end else begin
                    acc = wide[63:0];
                end
            end
            q = acc >>> FRAC_W;
            res.saturated = 1'b0;
            if (q > Q_MAX) begin
                q = Q_MAX;
                res.saturated = 1'b1;
            end else if (q < Q_MIN) begin
                q = Q_MIN;
                res.saturated = 1'b1;
            end
            res.sum = q[31:0];
            return res;
        endfunction

        // True when a product of this row touches only stores that were written.
        function bit row_readable(int unsigned r);
            int unsigned j;
            if (!start_set[r] || !start_set[r + 1]) return 0;
            for (j = row_start[r]; j < row_start[r + 1] && j < NZ_DEPTH; j++) begin
                if (!entry_set[j] || !vector_set[entry_column[j]]) return 0;
            end
            return 1;
        endfunction

        function int pending();
            return expected_sums.size();
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(logic [SUM_W-1:0] sum, logic saturated);
            row_result_t want;
            if (expected_sums.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result item: sum %h saturated %b", sum, saturated);
                return;
            end
            want = expected_sums.pop_front();
            if (sum !== want.sum || saturated !== want.saturated) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result mismatch: sum expected %h actual %h, saturated expected %b actual %b",
                             want.sum, sum, want.saturated, saturated);
            end
        endfunction
    endclass

endpackage

>>> tb/testbench.sv
// Self-checking testbench for the CSR sparse row dot product block.
`timescale 1ns / 100ps

module testbench;
    import crdp_pkg::*;
    import crdp_tb_pkg::*;

    localparam int PHASES          = 4;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int SETTLE_CYCLES   = 128;
    localparam int SEND_IDLE_PCT  [PHASES] = '{0, 76, 0, 21};
    localparam int RECV_STALL_PCT [PHASES] = '{0, 0, 76, 21};

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // Items that the block acts on; ignored loads are not counted.
    int loads_and_queries = 0;
    row_product_scoreboard sums;

    always #2 aclk = ~aclk;

    csr_row_dot_product_top u_top (
        .aclk,
        .aresetn,
        .s_tvalid,
        .s_tready,
        .s_tdata,
        .s_tuser,
        .m_tvalid,
        .m_tready,
        .m_tdata,
        .m_tuser
    );

    // Result side: check each accepted item, then choose next cycle's ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) sums.check_result(m_tdata, m_tuser[0]);
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Hard limit on the run time.
    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    // Offer one item after random gaps and hold it until it is taken.
    task automatic send_item(input crdp_item_t it);
        logic [S_TDATA_W-1:0] fields;
        fields = '0;
        fields[SLOT_LSB  +: SLOT_W]  = it.slot;
        fields[COL_LSB   +: COL_W]   = it.column;
        fields[DATUM_LSB +: DATUM_W] = it.datum;
        fields[ROW_LSB   +: ROW_W]   = it.target_row;
        fields[MODE_LSB  +: MODE_W]  = it.mode;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= fields;
        s_tuser  <= it.cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (sums.note_item(it)) loads_and_queries++;
    endtask

    // Loads carry random values in the fields they do not use.
    task automatic send_load(input cmd_t cmd, input logic [SLOT_W-1:0] slot,
                             input logic [COL_W-1:0] column, input logic [DATUM_W-1:0] datum);
        crdp_item_t it;
        it.cmd        = cmd;
        it.slot       = slot;
        it.column     = column;
        it.datum      = datum;
        it.target_row = $urandom;
        it.mode       = $urandom;
        send_item(it);
    endtask

    task automatic send_row_query(input logic [ROW_W-1:0] row, input logic [MODE_W-1:0] mode);
        crdp_item_t it;
        it.cmd        = CMD_ROW;
        it.slot       = $urandom;
        it.column     = $urandom;
        it.datum      = $urandom;
        it.target_row = row;
        it.mode       = mode;
        send_item(it);
    endtask

    // Mostly small values, some full-range ones and some extremes.
    function automatic logic [DATUM_W-1:0] random_q16();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        endcase
    endfunction

    // Try up to four random rows and ask for the first one whose stores are all written.
    task automatic query_random_row();
        int row;
        repeat (4) begin
            row = $urandom_range(0, ROW_DEPTH - 1);
            if (sums.row_readable(row)) begin
                send_row_query(row, $urandom);
                return;
            end
        end
    endtask

    // Random loads of any kind, most of them past the end of their store.
    task automatic scatter_loads();
        repeat ($urandom_range(1, 4))
            send_load(cmd_t'($urandom_range(0, 2)), $urandom_range(0, 2047), $urandom, $urandom);
    endtask

    // Build a few consecutive rows with ascending columns, then take their products.
    task automatic build_row_block();
        int row_count;
        int first_row;
        int first_entry;
        int total;
        int pos;
        int col;
        int i;
        int n;
        int lens [4];
        row_count = $urandom_range(1, 4);
        first_row = $urandom_range(0, ROW_DEPTH - row_count);
        total = 0;
        for (i = 0; i < row_count; i++) begin
            lens[i] = ($urandom_range(0, 29) == 0) ? $urandom_range(20, 64) : $urandom_range(0, 6);
            total += lens[i];
        end
        first_entry = $urandom_range(0, NZ_DEPTH - total);

        // Row pointers in ascending order
        pos = first_entry;
        send_load(CMD_LOAD_PTR, first_row, $urandom, pos);
        for (i = 0; i < row_count; i++) begin
            pos += lens[i];
            send_load(CMD_LOAD_PTR, first_row + i + 1, $urandom, pos);
        end

        // Now and then one pointer is overwritten, which may reverse or stretch a row.
        if ($urandom_range(0, 9) == 0)
            send_load(CMD_LOAD_PTR, first_row + $urandom_range(0, row_count), $urandom,
                      $urandom_range(0, 1) ? $urandom : $urandom_range(0, NZ_DEPTH + 100));

        // Entries with ascending columns, mostly starting near the diagonal
        pos = first_entry;
        for (i = 0; i < row_count; i++) begin
            if ($urandom_range(0, 3) == 0) col = $urandom_range(0, 255);
            else col = first_row + i - int'($urandom_range(0, 12));
            if (col < 0) col = 0;
            for (n = 0; n < lens[i]; n++) begin
                send_load(CMD_LOAD_ENTRY, pos, col, random_q16());
                if (!sums.vector_set[col] || $urandom_range(0, 2) == 0)
                    send_load(CMD_LOAD_VEC, col, $urandom, random_q16());
                pos++;
                col += $urandom_range(0, 6);
                if (col > 255) col = 255;
            end
        end

        // Products of the new rows in random modes
        for (i = 0; i < row_count; i++) begin
            if (sums.row_readable(first_row + i)) send_row_query(first_row + i, $urandom);
        end
        if ($urandom_range(0, 1) == 1) query_random_row();
    endtask

    // Extremes and each special case, on a tiny hand-built matrix.
    task automatic run_directed();
        logic [DATUM_W-1:0] ptr_values [8] = '{32'd0, 32'd2, 32'd3, 32'd4, 32'd5, 32'd2,
                                              32'hFFFF_FFFF, 32'h0000_1000};
        int i;
        // Vector extremes, the smallest positive step, and a slot past the end
        send_load(CMD_LOAD_VEC, 0, $urandom, 32'h8000_0000);
        send_load(CMD_LOAD_VEC, 255, $urandom, 32'h7FFF_FFFF);
        send_load(CMD_LOAD_VEC, 1, $urandom, 32'h0000_0001);
        send_load(CMD_LOAD_VEC, ROW_DEPTH, $urandom, 32'hDEAD_BEEF);

        // Row 0 holds two products of 2^62, which overflow the accumulator.
        send_load(CMD_LOAD_ENTRY, 0, 0, 32'h8000_0000);
        send_load(CMD_LOAD_ENTRY, 1, 0, 32'h8000_0000);
        // Row 1 holds -1 times the smallest step, which floors to -1.
        send_load(CMD_LOAD_ENTRY, 2, 1, 32'hFFFF_FFFF);
        // Rows 2 and 3 hold one product each, far above and far below the range.
        send_load(CMD_LOAD_ENTRY, 3, 255, 32'h7FFF_FFFF);
        send_load(CMD_LOAD_ENTRY, 4, 255, 32'h8000_0000);
        send_load(CMD_LOAD_ENTRY, 11'h7FF, 8'hFF, 32'h1234_5678);

        // Row 4 is reversed; row 6 is empty at the clamped end of the store.
        for (i = 0; i < 8; i++) send_load(CMD_LOAD_PTR, i, $urandom, ptr_values[i]);
        send_load(CMD_LOAD_PTR, ROW_DEPTH, $urandom, 32'd0);
        send_load(CMD_LOAD_PTR, ROW_DEPTH + 1, $urandom, 32'd0);

        send_row_query(0, MODE_FULL);
        send_row_query(0, MODE_UPPER);
        send_row_query(1, MODE_FULL);
        send_row_query(1, MODE_LOWER);
        send_row_query(2, MODE_UPPER);
        send_row_query(3, MODE_SPARE);
        send_row_query(4, MODE_FULL);
        send_row_query(6, MODE_LOWER);
    endtask

    // Main sequence: reset, directed items, then random phases with drains between.
    initial begin
        int phase;
        int target;
        int pick;
        sums = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        for (phase = 0; phase < PHASES; phase++) begin
            send_idle_pct  = SEND_IDLE_PCT[phase];
            recv_stall_pct = RECV_STALL_PCT[phase];
            target = loads_and_queries + ITEMS_PER_PHASE;
            while (loads_and_queries < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) build_row_block();
                else if (pick < 85) scatter_loads();
                else query_random_row();
            end
            // Hold the input side until every pending result has come back.
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (sums.pending() != 0);
        end

        // Give a stray result time to appear before the verdict.
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sums.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> csr_row_dot_product_top.f
sv/crdp_pkg.sv
sv/crdp_ctrl.sv
sv/crdp_dp.sv
sv/csr_row_dot_product_top.sv
sv/crdp_chk.sv
tb/crdp_tb_pkg.sv
tb/testbench.sv
